// ----- src/mm16_pkg.sv -----
// ----------------------------------------------------------------------------
// mm16_pkg
// Shared types and constants of the 16-bit instruction execute step: field
// widths, opcode and funct codes, and the transaction payloads.
// ----------------------------------------------------------------------------
package mm16_pkg;

  // widths fixed by the instruction set and the result format
  localparam int INSTR_W      = 16;
  localparam int PC_W         = 13;
  localparam int WORD_W       = 32;
  localparam int REG_IDX_W    = 3;
  localparam int NUM_REGS     = 8;
  localparam int IMM_W        = 6;
  localparam int JADDR_W      = 12;
  localparam int OPCODE_W     = 4;
  localparam int FUNCT_W      = 3;
  localparam int MEM_ADDR_W   = 8;

  // default data memory depth in words
  localparam int DATA_WORDS   = 256;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_RTYPE = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_JUMP  = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_LW    = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_SW    = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_ADDI  = 4'd8;
  localparam logic [OPCODE_W-1:0] OP_BEQ   = 4'd9;

  // r-type funct codes
  localparam logic [FUNCT_W-1:0] FN_ADD = 3'd0;
  localparam logic [FUNCT_W-1:0] FN_SUB = 3'd1;
  localparam logic [FUNCT_W-1:0] FN_AND = 3'd2;
  localparam logic [FUNCT_W-1:0] FN_OR  = 3'd3;

  // fetch transaction payload
  typedef struct packed {
    logic [INSTR_W-1:0] instruction;
  } fetch_t;

  // retire transaction payload
  typedef struct packed {
    logic [PC_W-1:0]         next_pc;
    logic                    halted;
    logic                    reg_written;
    logic [REG_IDX_W-1:0]    reg_index;
    logic signed [WORD_W-1:0] reg_value;
    logic                    mem_written;
    logic [MEM_ADDR_W-1:0]   mem_address;
    logic signed [WORD_W-1:0] mem_value;
    logic                    branch_error;
  } retire_t;

endpackage

// ----- src/mm16_stream_if.sv -----
// ----------------------------------------------------------------------------
// mm16_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mm16_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/mini_mips16_execute_step.sv -----
// ----------------------------------------------------------------------------
// mini_mips16_execute_step
// Executes one 16-bit instruction per transaction against a register file,
// a data memory and the program counter, and retires one result each.
// ----------------------------------------------------------------------------
// Takes one instruction per clock and retires one result per clock when the
// retire side keeps ready high, each result passing the execute and retire
// registers. The register file is a two-read, one-write synchronous memory
// read at fetch, the data memory a one-read, one-write synchronous memory read
// in the execute stage, and register writes land when the result retires; the
// execute stage forwards from the retiring result and from the write that
// coincided with its register read, so back-to-back dependent instructions run
// at full rate. After reset the data memory is swept to zero, one word per
// cycle, through all DATA_WORDS words (256 by default), while fetch.ready is
// low; program_length can be written meanwhile. DATA_WORDS must be a power of
// two; data addresses wrap modulo DATA_WORDS.
module mini_mips16_execute_step #(
  parameter int DATA_WORDS = mm16_pkg::DATA_WORDS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mm16_pkg::PC_W-1:0] cfg_data,
  mm16_stream_if.sink               fetch,
  mm16_stream_if.source             retire
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam logic [mm16_pkg::MEM_ADDR_W-1:0] ADDR_OUT_MASK =
    mm16_pkg::MEM_ADDR_W'((DATA_WORDS - 1) % 256);
  localparam int TGT_W = mm16_pkg::PC_W + 1;

  // configuration and architectural pc
  logic [mm16_pkg::PC_W-1:0] program_length;
  logic [mm16_pkg::PC_W-1:0] pc;

  // data memory clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // register file memory with per-entry valid bits
  logic [mm16_pkg::WORD_W-1:0] rf_mem [mm16_pkg::NUM_REGS];
  logic [mm16_pkg::NUM_REGS-1:0] rf_valid;
  logic [mm16_pkg::WORD_W-1:0] rf_rd_s, rf_rd_t;
  logic                        rf_ok_s, rf_ok_t;

  // data memory
  logic [mm16_pkg::WORD_W-1:0] dmem [DATA_WORDS];
  logic [mm16_pkg::WORD_W-1:0] dm_rdata;

  // execute stage
  logic                         s1_valid;
  logic [mm16_pkg::INSTR_W-1:0] s1_instr;

  // write that happened at the edge of the last register read
  logic                           wb_valid;
  logic [mm16_pkg::REG_IDX_W-1:0] wb_idx;
  logic [mm16_pkg::WORD_W-1:0]    wb_val;

  // retire stage
  logic              s2_valid;
  mm16_pkg::retire_t s2_res;
  logic              s2_load;

  // handshake
  logic accept_in, out_fire, s1_en, s1_move, s2_en;
  logic wr_en;
  logic [mm16_pkg::WORD_W-1:0] s2_wval;

  // execute stage decode and results
  logic [mm16_pkg::OPCODE_W-1:0]  op;
  logic [mm16_pkg::REG_IDX_W-1:0] rs, rt, rd;
  logic [mm16_pkg::FUNCT_W-1:0]   funct;
  logic [mm16_pkg::IMM_W-1:0]     imm;
  logic [mm16_pkg::JADDR_W-1:0]   jaddr;
  logic [mm16_pkg::WORD_W-1:0]    opa, opb, imm32, sum_addr, alu_res;
  logic [AW-1:0]                  dm_addr;
  logic [mm16_pkg::PC_W-1:0]      pc_inc;
  logic [TGT_W-1:0]               target;
  logic                           halt, store_en, load_en;
  mm16_pkg::retire_t              res;

  // handshake and stage enables
  assign s2_en     = !s2_valid || retire.ready;
  assign s1_en     = !s1_valid || s2_en;
  assign s1_move   = s1_valid && s2_en;
  assign out_fire  = s2_valid && retire.ready;
  assign fetch.ready = !clearing && s1_en;
  assign accept_in = fetch.valid && fetch.ready;

  // retiring register write
  assign s2_wval = s2_load ? dm_rdata : mm16_pkg::WORD_W'(s2_res.reg_value);
  assign wr_en   = out_fire && s2_res.reg_written;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_we) begin
      program_length <= cfg_data;
    end
  end

  // clearing sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DATA_WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // register file read at fetch, write at retire
  always_ff @(posedge clk) begin
    if (accept_in) begin
      rf_rd_s <= rf_mem[fetch.data.instruction[11:9]];
      rf_rd_t <= rf_mem[fetch.data.instruction[8:6]];
      rf_ok_s <= rf_valid[fetch.data.instruction[11:9]];
      rf_ok_t <= rf_valid[fetch.data.instruction[8:6]];
    end
    if (wr_en) begin
      rf_mem[s2_res.reg_index] <= s2_wval;
    end
  end

  // register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (wr_en) begin
      rf_valid[s2_res.reg_index] <= 1'b1;
    end
  end

  // write coinciding with the register read
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (s1_en) begin
      wb_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      wb_idx <= s2_res.reg_index;
      wb_val <= s2_wval;
    end
  end

  // execute stage pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= accept_in;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_instr <= fetch.data.instruction;
    end
  end

  // field decode
  assign op    = s1_instr[15:12];
  assign rs    = s1_instr[11:9];
  assign rt    = s1_instr[8:6];
  assign rd    = s1_instr[5:3];
  assign funct = s1_instr[2:0];
  assign imm   = s1_instr[5:0];
  assign jaddr = s1_instr[11:0];

  // operand forwarding: retiring result, then coinciding write, then memory
  always_comb begin
    if (s2_valid && s2_res.reg_written && s2_res.reg_index == rs) begin
      opa = s2_wval;
    end else if (wb_valid && wb_idx == rs) begin
      opa = wb_val;
    end else begin
      opa = rf_ok_s ? rf_rd_s : '0;
    end
    if (s2_valid && s2_res.reg_written && s2_res.reg_index == rt) begin
      opb = s2_wval;
    end else if (wb_valid && wb_idx == rt) begin
      opb = wb_val;
    end else begin
      opb = rf_ok_t ? rf_rd_t : '0;
    end
  end

  // alu and address arithmetic
  assign imm32    = mm16_pkg::WORD_W'(imm);
  assign sum_addr = opa + imm32;
  assign dm_addr  = sum_addr[AW-1:0];
  assign pc_inc   = pc + 1'b1;
  assign target   = TGT_W'(pc) + TGT_W'(1) + TGT_W'(imm);
  assign halt     = pc >= program_length;

  always_comb begin
    case (funct)
      mm16_pkg::FN_ADD: alu_res = opa + opb;
      mm16_pkg::FN_SUB: alu_res = opa - opb;
      mm16_pkg::FN_AND: alu_res = opa & opb;
      mm16_pkg::FN_OR:  alu_res = opa | opb;
      default:          alu_res = '0;
    endcase
  end

  // result of the step
  always_comb begin
    res         = '0;
    res.next_pc = pc;
    load_en     = 1'b0;
    store_en    = 1'b0;
    if (halt) begin
      res.halted = 1'b1;
    end else begin
      res.next_pc = pc_inc;
      case (op)
        mm16_pkg::OP_RTYPE: begin
          res.reg_written = 1'b1;
          res.reg_index   = rd;
          res.reg_value   = alu_res;
        end
        mm16_pkg::OP_JUMP: begin
          if (mm16_pkg::PC_W'(jaddr) != pc) begin
            res.next_pc = mm16_pkg::PC_W'(jaddr);
          end
        end
        mm16_pkg::OP_ADDI: begin
          res.reg_written = 1'b1;
          res.reg_index   = rt;
          res.reg_value   = sum_addr;
        end
        mm16_pkg::OP_BEQ: begin
          if (opa == opb) begin
            if (target < TGT_W'(program_length)) begin
              res.next_pc = target[mm16_pkg::PC_W-1:0];
            end else begin
              res.next_pc      = program_length;
              res.branch_error = 1'b1;
            end
          end
        end
        mm16_pkg::OP_LW: begin
          res.reg_written = 1'b1;
          res.reg_index   = rt;
          load_en         = 1'b1;
        end
        mm16_pkg::OP_SW: begin
          res.mem_written = 1'b1;
          res.mem_address = sum_addr[mm16_pkg::MEM_ADDR_W-1:0] & ADDR_OUT_MASK;
          res.mem_value   = opb;
          store_en        = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // data memory: clearing sweep, store and load
  always_ff @(posedge clk) begin
    if (clearing) begin
      dmem[clr_addr] <= '0;
    end else if (s1_move && store_en) begin
      dmem[dm_addr] <= opb;
    end
    if (s1_move && load_en) begin
      dm_rdata <= dmem[dm_addr];
    end
  end

  // program counter advances as each step leaves execute
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s1_move) begin
      pc <= res.next_pc;
    end
  end

  // retire stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_res  <= res;
      s2_load <= load_en;
    end
  end

  // retire transaction
  assign retire.valid = s2_valid;
  always_comb begin
    retire.data = s2_res;
    if (s2_load) begin
      retire.data.reg_value = dm_rdata;
    end
  end

  // checks
  a_clear_blocks_fetch: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !fetch.ready)
    else $error("fetch accepted during data memory clearing");

  a_halt_no_effect: assert property (@(posedge clk) disable iff (rst)
    (retire.valid && retire.data.halted) |->
      (!retire.data.reg_written && !retire.data.mem_written && !retire.data.branch_error))
    else $error("halted step reports a side effect");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    retire.valid |-> !(retire.data.reg_written && retire.data.mem_written))
    else $error("step writes both register and memory");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == AW'(DATA_WORDS - 1))
    else $error("clearing sweep ended early");

endmodule
